>>> rtl/lz11d_pkg.sv
`timescale 1ns / 1ps
package lz11d_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_COPY,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_FIN  = 3'd1;
  localparam logic [2:0] ST_CAP  = 3'd2;
  localparam logic [2:0] ST_DISP = 3'd3;
  localparam logic [2:0] ST_OVER = 3'd4;
  localparam logic [2:0] ST_TURN = 3'd5;

  localparam logic [8:0]  SHORT_BIAS = 9'h011;
  localparam logic [16:0] LONG_BIAS  = 17'h00111;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        last;
    logic        copy_pending;
    logic [2:0]  status;
    logic [24:0] consumed;
  } result_t;

endpackage

>>> rtl/lz11d_if.sv
`timescale 1ns / 1ps
interface lz11d_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface lz11d_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        last;
  logic        copy_pending;
  logic [2:0]  status;
  logic [24:0] consumed;
  modport source (output valid, output byte_valid, output out_byte, output last,
                  output copy_pending, output status, output consumed, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input last,
                input copy_pending, input status, input consumed, output ready);
endinterface

>>> rtl/lz11d_ram.sv
`timescale 1ns / 1ps
module lz11d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lz11d_core.sv
`timescale 1ns / 1ps
module lz11d_core #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [23:0]   cfg_wdata,
  lz11d_in_if.sink      in_ch,
  lz11d_out_if.source   out_ch,
  output logic          hist_we,
  output logic [AW-1:0] hist_waddr,
  output logic [7:0]    hist_wdata,
  output logic [AW-1:0] hist_raddr,
  input  logic [7:0]    hist_rdata
);

  lz11d_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [23:0] total_r, total_nxt;
  logic [23:0] prod_r, prod_nxt;
  logic [24:0] cons_r, cons_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  fpos_r, fpos_nxt;
  logic [23:0] tok_r, tok_nxt;
  logic [1:0]  tidx_r, tidx_nxt;
  logic [16:0] left_r, left_nxt;
  logic [12:0] dist_r, dist_nxt;
  logic [2:0]  sticky_r, sticky_nxt;
  logic [23:0] cap_r;
  logic        out_valid_r;
  lz11d_pkg::result_t res_r, res_nxt;
  logic        byp_r;
  logic [7:0]  byp_data_r;

  logic        accept;
  logic [7:0]  din;
  logic [31:0] win;
  logic [7:0]  tok_a;
  logic [3:0]  tok_hi;
  logic        tok_done;
  logic [16:0] tok_count;
  logic [12:0] tok_disp;
  logic [7:0]  hist_byte;
  logic [23:0] prod_inc;
  logic [24:0] end_sum;
  logic        flag_bit;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign din         = in_ch.data_byte;
  assign win         = {tok_r, din};
  assign hist_byte   = byp_r ? byp_data_r : hist_rdata;
  assign prod_inc    = prod_r + 24'd1;
  assign flag_bit    = flags_r[3'd7 - fpos_r[2:0]];

  always_comb begin
    case (tidx_r)
      2'd0:    tok_a = din;
      2'd1:    tok_a = tok_r[7:0];
      2'd2:    tok_a = tok_r[15:8];
      default: tok_a = tok_r[23:16];
    endcase
    tok_hi = tok_a[7:4];
    if (tok_hi == 4'd0) begin
      tok_done  = (tidx_r == 2'd2);
      tok_count = {9'd0, win[19:16], win[15:12]} + {8'd0, lz11d_pkg::SHORT_BIAS};
      tok_disp  = {1'b0, win[11:0]} + 13'd1;
    end else if (tok_hi == 4'd1) begin
      tok_done  = (tidx_r == 2'd3);
      tok_count = {1'b0, win[27:12]} + lz11d_pkg::LONG_BIAS;
      tok_disp  = {1'b0, win[11:0]} + 13'd1;
    end else begin
      tok_done  = (tidx_r == 2'd1);
      tok_count = {13'd0, tok_hi} + 17'd1;
      tok_disp  = {1'b0, win[11:0]} + 13'd1;
    end
    end_sum = {1'b0, prod_r} + {8'd0, tok_count};
  end

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    total_nxt  = total_r;
    prod_nxt   = prod_r;
    cons_nxt   = cons_r;
    flags_nxt  = flags_r;
    fpos_nxt   = fpos_r;
    tok_nxt    = tok_r;
    tidx_nxt   = tidx_r;
    left_nxt   = left_r;
    dist_nxt   = dist_r;
    sticky_nxt = sticky_r;
    res_nxt    = '0;
    hist_we    = 1'b0;
    hist_wdata = din;
    if (accept) begin
      if (phase_r == lz11d_pkg::PH_DONE) begin
        res_nxt.status   = lz11d_pkg::ST_FIN;
        res_nxt.consumed = cons_r;
      end else if (phase_r == lz11d_pkg::PH_ERROR) begin
        res_nxt.status = sticky_r;
      end else if (in_ch.action) begin
        if (phase_r != lz11d_pkg::PH_COPY || left_r == 17'd0) begin
          res_nxt.status = lz11d_pkg::ST_TURN;
        end else begin
          hist_we            = 1'b1;
          hist_wdata         = hist_byte;
          prod_nxt           = prod_inc;
          res_nxt.byte_valid = 1'b1;
          res_nxt.out_byte   = hist_byte;
          left_nxt           = left_r - 17'd1;
          if (left_r == 17'd1) begin
            if (prod_inc == total_r) begin
              phase_nxt        = lz11d_pkg::PH_DONE;
              sticky_nxt       = lz11d_pkg::ST_FIN;
              res_nxt.last     = 1'b1;
              res_nxt.status   = lz11d_pkg::ST_FIN;
              res_nxt.consumed = cons_r;
            end else begin
              tidx_nxt  = 2'd0;
              tok_nxt   = '0;
              phase_nxt = fpos_r[3] ? lz11d_pkg::PH_FLAG : lz11d_pkg::PH_TOKEN;
            end
          end else begin
            res_nxt.copy_pending = 1'b1;
          end
        end
      end else if (phase_r == lz11d_pkg::PH_COPY) begin
        res_nxt.copy_pending = 1'b1;
        res_nxt.status       = lz11d_pkg::ST_TURN;
      end else begin
        cons_nxt = cons_r + 25'd1;
        case (phase_r)
          lz11d_pkg::PH_HEADER: begin
            case (hidx_r)
              2'd1:    total_nxt[7:0]   = total_r[7:0] | din;
              2'd2:    total_nxt[15:8]  = total_r[15:8] | din;
              2'd3:    total_nxt[23:16] = total_r[23:16] | din;
              default: total_nxt        = total_r;
            endcase
            hidx_nxt = hidx_r + 2'd1;
            if (hidx_r == 2'd3) begin
              if (total_nxt > cap_r) begin
                phase_nxt      = lz11d_pkg::PH_ERROR;
                sticky_nxt     = lz11d_pkg::ST_CAP;
                left_nxt       = '0;
                res_nxt.status = lz11d_pkg::ST_CAP;
              end else if (total_nxt == 24'd0) begin
                phase_nxt        = lz11d_pkg::PH_DONE;
                sticky_nxt       = lz11d_pkg::ST_FIN;
                res_nxt.status   = lz11d_pkg::ST_FIN;
                res_nxt.consumed = cons_nxt;
              end else begin
                fpos_nxt  = 4'd8;
                phase_nxt = lz11d_pkg::PH_FLAG;
              end
            end
          end
          lz11d_pkg::PH_FLAG: begin
            flags_nxt = din;
            fpos_nxt  = 4'd0;
            tidx_nxt  = 2'd0;
            tok_nxt   = '0;
            phase_nxt = lz11d_pkg::PH_TOKEN;
          end
          default: begin
            if (tidx_r == 2'd0 && !flag_bit) begin
              hist_we            = 1'b1;
              prod_nxt           = prod_inc;
              res_nxt.byte_valid = 1'b1;
              res_nxt.out_byte   = din;
              fpos_nxt           = fpos_r + 4'd1;
              if (prod_inc == total_r) begin
                phase_nxt        = lz11d_pkg::PH_DONE;
                sticky_nxt       = lz11d_pkg::ST_FIN;
                res_nxt.last     = 1'b1;
                res_nxt.status   = lz11d_pkg::ST_FIN;
                res_nxt.consumed = cons_nxt;
              end else begin
                tidx_nxt  = 2'd0;
                tok_nxt   = '0;
                phase_nxt = fpos_nxt[3] ? lz11d_pkg::PH_FLAG : lz11d_pkg::PH_TOKEN;
              end
            end else if (!tok_done) begin
              tok_nxt  = win[23:0];
              tidx_nxt = tidx_r + 2'd1;
            end else begin
              tidx_nxt = 2'd0;
              tok_nxt  = '0;
              if ({11'd0, tok_disp} > prod_r) begin
                phase_nxt      = lz11d_pkg::PH_ERROR;
                sticky_nxt     = lz11d_pkg::ST_DISP;
                left_nxt       = '0;
                res_nxt.status = lz11d_pkg::ST_DISP;
              end else if (end_sum > {1'b0, total_r}) begin
                phase_nxt      = lz11d_pkg::PH_ERROR;
                sticky_nxt     = lz11d_pkg::ST_OVER;
                left_nxt       = '0;
                res_nxt.status = lz11d_pkg::ST_OVER;
              end else begin
                fpos_nxt             = fpos_r + 4'd1;
                left_nxt             = tok_count;
                dist_nxt             = tok_disp;
                phase_nxt            = lz11d_pkg::PH_COPY;
                res_nxt.copy_pending = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  assign hist_waddr = prod_r[AW-1:0];
  assign hist_raddr = prod_nxt[AW-1:0] - dist_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lz11d_pkg::PH_HEADER;
      hidx_r      <= '0;
      total_r     <= '0;
      prod_r      <= '0;
      cons_r      <= '0;
      flags_r     <= '0;
      fpos_r      <= 4'd8;
      tok_r       <= '0;
      tidx_r      <= '0;
      left_r      <= '0;
      dist_r      <= '0;
      sticky_r    <= lz11d_pkg::ST_RUN;
      cap_r       <= 24'hFFFFFF;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      total_r  <= total_nxt;
      prod_r   <= prod_nxt;
      cons_r   <= cons_nxt;
      flags_r  <= flags_nxt;
      fpos_r   <= fpos_nxt;
      tok_r    <= tok_nxt;
      tidx_r   <= tidx_nxt;
      left_r   <= left_nxt;
      dist_r   <= dist_nxt;
      sticky_r <= sticky_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
      byp_r <= hist_we && (hist_raddr == hist_waddr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
    byp_data_r <= hist_wdata;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_valid   = res_r.byte_valid;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.last         = res_r.last;
  assign out_ch.copy_pending = res_r.copy_pending;
  assign out_ch.status       = res_r.status;
  assign out_ch.consumed     = res_r.consumed;

endmodule

>>> rtl/lz11_decompressor.sv
`timescale 1ns / 1ps
// LZ11 stream decompressor. The in_ch channel takes one item per transfer:
// action 0 carries one compressed byte, action 1 advances a pending
// back-reference copy by one byte. Every input transfer yields exactly one
// result transfer on out_ch, carrying the output byte if any, the last flag,
// copy_pending, the status code and, once finished, the consumed byte count.
// The result register is loaded at the input transfer's edge and offered in
// the next cycle; one item is taken every cycle while out_ch does not stall.
// The history is a WINDOW_DEPTH-byte RAM whose read address for the next
// copy byte is issued together with each state update, with a bypass for a distance of one.
// The output_capacity register is written through cfg_we and cfg_wdata.
// A synchronous reset on rst_n returns the parser to the header, clears the
// counters and error status, and sets the capacity to its maximum; the
// history is not cleared. When out_ch stalls, the held result stays put and
// in_ch.ready drops until it is taken.
module lz11_decompressor #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  lz11d_in_if.sink    in_ch,
  lz11d_out_if.source out_ch
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic [7:0]    hist_wdata;
  logic [AW-1:0] hist_raddr;
  logic [7:0]    hist_rdata;

  lz11d_core #(.AW(AW)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .hist_rdata (hist_rdata)
  );

  lz11d_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

endmodule

>>> test/lz11_decompressor_tb.sv
`timescale 1ns / 1ps
module lz11_decompressor_tb;

  localparam int WIN = 4096;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit                 act;
    logic [7:0]         data;
    bit                 typed;
    lz11d_pkg::result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  lz11d_in_if  in_ch();
  lz11d_out_if out_ch();

  lz11_decompressor u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  lz11d_pkg::phase_t m_phase;
  int          m_hdr_idx;
  logic [23:0] m_size;
  logic [23:0] m_made;
  logic [23:0] m_cap;
  logic [24:0] m_used;
  logic [7:0]  m_flags;
  int          m_fpos;
  logic [23:0] m_tok;
  int          m_tidx;
  int          m_left;
  int          m_dist;
  logic [2:0]  m_sticky;
  logic [7:0]  m_hist [WIN];

  lz11d_pkg::result_t expected_results[$];
  stim_row_t stim_rows[$];
  logic [7:0] token_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void emit(logic [7:0] b, ref lz11d_pkg::result_t r);
    m_hist[m_made[11:0]] = b;
    m_made = m_made + 24'd1;
    r.byte_valid = 1'b1;
    r.out_byte = b;
  endfunction

  function automatic void finish_stream(ref lz11d_pkg::result_t r);
    m_phase = lz11d_pkg::PH_DONE;
    m_sticky = lz11d_pkg::ST_FIN;
    r.last = 1'b1;
    r.status = lz11d_pkg::ST_FIN;
    r.consumed = m_used;
  endfunction

  function automatic void fail_stream(logic [2:0] code, ref lz11d_pkg::result_t r);
    m_phase = lz11d_pkg::PH_ERROR;
    m_sticky = code;
    m_left = 0;
    r.status = code;
  endfunction

  function automatic void next_token();
    m_tidx = 0;
    m_tok = '0;
    m_phase = (m_fpos >= 8) ? lz11d_pkg::PH_FLAG : lz11d_pkg::PH_TOKEN;
  endfunction

  function automatic void token_byte(logic [7:0] b, ref lz11d_pkg::result_t r);
    int k;
    int bb [4];
    int hi;
    int need;
    int cnt;
    int disp;
    k = m_tidx;
    for (int i = 0; i < 4; i++) bb[i] = 0;
    for (int i = 0; i < k && i < 3; i++)
      bb[i] = int'((m_tok >> (8 * (k - 1 - i))) & 24'hFF);
    bb[k & 3] = int'(b);
    hi = bb[0] >> 4;
    need = (hi == 0) ? 3 : (hi == 1) ? 4 : 2;
    if (k + 1 < need) begin
      m_tok = {m_tok[15:0], b};
      m_tidx = k + 1;
      return;
    end
    if (hi == 0) begin
      cnt = (((bb[0] & 15) << 4) | (bb[1] >> 4)) + 'h11;
      disp = (((bb[1] & 15) << 8) | bb[2]) + 1;
    end else if (hi == 1) begin
      cnt = (((bb[0] & 15) << 12) | (bb[1] << 4) | (bb[2] >> 4)) + 'h111;
      disp = (((bb[2] & 15) << 8) | bb[3]) + 1;
    end else begin
      cnt = hi + 1;
      disp = (((bb[0] & 15) << 8) | bb[1]) + 1;
    end
    m_tidx = 0;
    m_tok = '0;
    if (disp > int'(m_made)) begin
      fail_stream(lz11d_pkg::ST_DISP, r);
      return;
    end
    if (int'(m_made) + cnt > int'(m_size)) begin
      fail_stream(lz11d_pkg::ST_OVER, r);
      return;
    end
    m_fpos++;
    m_left = cnt;
    m_dist = disp;
    m_phase = lz11d_pkg::PH_COPY;
    r.copy_pending = 1'b1;
  endfunction

  function automatic lz11d_pkg::result_t lz_predict(bit act, logic [7:0] b);
    lz11d_pkg::result_t r;
    logic [23:0] src;
    r = '0;
    if (m_phase == lz11d_pkg::PH_DONE) begin
      r.status = lz11d_pkg::ST_FIN;
      r.consumed = m_used;
      return r;
    end
    if (m_phase == lz11d_pkg::PH_ERROR) begin
      r.status = m_sticky;
      return r;
    end
    if (act) begin
      if (m_phase != lz11d_pkg::PH_COPY || m_left == 0) begin
        r.status = lz11d_pkg::ST_TURN;
        return r;
      end
      src = m_made - 24'(m_dist);
      emit(m_hist[src[11:0]], r);
      m_left--;
      if (m_left == 0) begin
        if (m_made == m_size) finish_stream(r);
        else next_token();
      end else begin
        r.copy_pending = 1'b1;
      end
      return r;
    end
    if (m_phase == lz11d_pkg::PH_COPY) begin
      r.copy_pending = 1'b1;
      r.status = lz11d_pkg::ST_TURN;
      return r;
    end
    m_used = m_used + 25'd1;
    case (m_phase)
      lz11d_pkg::PH_HEADER: begin
        if (m_hdr_idx != 0) m_size = m_size | (24'(b) << (8 * (m_hdr_idx - 1)));
        m_hdr_idx = (m_hdr_idx + 1) & 3;
        if (m_hdr_idx == 0) begin
          if (m_size > m_cap) fail_stream(lz11d_pkg::ST_CAP, r);
          else if (m_size == 0) begin
            finish_stream(r);
            r.last = 1'b0;
          end else begin
            m_fpos = 8;
            m_phase = lz11d_pkg::PH_FLAG;
          end
        end
      end
      lz11d_pkg::PH_FLAG: begin
        m_flags = b;
        m_fpos = 0;
        m_tidx = 0;
        m_tok = '0;
        m_phase = lz11d_pkg::PH_TOKEN;
      end
      default: begin
        if (m_tidx == 0 && m_flags[7 - (m_fpos & 7)] == 1'b0) begin
          emit(b, r);
          m_fpos++;
          if (m_made == m_size) finish_stream(r);
          else next_token();
        end else begin
          token_byte(b, r);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int idle_len();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(bit act, logic [7:0] b, bit typed, lz11d_pkg::result_t want);
    lz11d_pkg::result_t p;
    int n;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data_byte <= b;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    p = lz_predict(act, b);
    expected_results.push_back(typed ? want : p);
    n = idle_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_cap(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    m_cap = v;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_row(bit act, logic [7:0] b, bit typed, lz11d_pkg::result_t r);
    stim_row_t row;
    row.act = act;
    row.data = b;
    row.typed = typed;
    row.res = r;
    stim_rows.push_back(row);
  endfunction

  function automatic lz11d_pkg::result_t mk(bit bv, logic [7:0] ob, logic [2:0] st);
    lz11d_pkg::result_t r;
    r = '0;
    r.byte_valid = bv;
    r.out_byte = ob;
    r.status = st;
    return r;
  endfunction

  function automatic void queue_token(bit overrun);
    int rem;
    int lim;
    int cnt;
    int d;
    int f;
    int sel;
    rem = int'(m_size) - int'(m_made);
    lim = (int'(m_made) < WIN) ? int'(m_made) : WIN;
    sel = $urandom_range(0, 3);
    d = (sel == 0) ? 1 : (sel == 1) ? lim : $urandom_range(1, lim);
    d = d - 1;
    sel = $urandom_range(0, 19);
    if (overrun && rem < 15) begin
      cnt = (rem + 1 < 3) ? 3 : rem + 1;
      token_q.push_back({4'(cnt - 1), 4'(d >> 8)});
      token_q.push_back(8'(d));
    end else if (sel == 0 && rem >= 400) begin
      f = $urandom_range(0, 100);
      token_q.push_back({4'h1, 4'(f >> 12)});
      token_q.push_back(8'(f >> 4));
      token_q.push_back({4'(f), 4'(d >> 8)});
      token_q.push_back(8'(d));
    end else if (sel < 5 && rem >= 17) begin
      f = $urandom_range(0, ((rem < 272) ? rem : 272) - 17);
      token_q.push_back({4'h0, 4'(f >> 4)});
      token_q.push_back({4'(f), 4'(d >> 8)});
      token_q.push_back(8'(d));
    end else begin
      cnt = (rem < 3) ? 3 : $urandom_range(3, (rem < 16) ? rem : 16);
      token_q.push_back({4'(cnt - 1), 4'(d >> 8)});
      token_q.push_back(8'(d));
    end
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    lz11d_pkg::result_t got;
    lz11d_pkg::result_t want;
    bit take;
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      take = out_ch.valid && out_ch.ready;
      got.byte_valid = out_ch.byte_valid;
      got.out_byte = out_ch.out_byte;
      got.last = out_ch.last;
      got.copy_pending = out_ch.copy_pending;
      got.status = out_ch.status;
      got.consumed = out_ch.consumed;
      @(posedge clk);
      if (take) begin
        if (expected_results.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.byte_valid !== want.byte_valid)
            report("byte_valid", got.byte_valid, want.byte_valid);
          if (got.out_byte !== want.out_byte)
            report("out_byte", got.out_byte, want.out_byte);
          if (got.last !== want.last) report("last", got.last, want.last);
          if (got.copy_pending !== want.copy_pending)
            report("copy_pending", got.copy_pending, want.copy_pending);
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.consumed !== want.consumed)
            report("consumed", got.consumed, want.consumed);
        end
      end
      if (stall > 0) stall--;
      else if (!no_idle && $urandom_range(0, 9) < 3)
        stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ch.ready <= (stall == 0);
    end
  end

  initial begin
    logic [23:0] size;
    bit overrun;
    bit act;
    logic [7:0] b;
    int items;
    int tail;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.data_byte = 8'h00;
    m_phase = lz11d_pkg::PH_HEADER;
    m_hdr_idx = 0;
    m_size = '0;
    m_made = '0;
    m_cap = 24'hFFFFFF;
    m_used = '0;
    m_flags = '0;
    m_fpos = 8;
    m_tok = '0;
    m_tidx = 0;
    m_left = 0;
    m_dist = 0;
    m_sticky = lz11d_pkg::ST_RUN;
    for (int i = 0; i < WIN; i++) m_hist[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    size = 24'($urandom_range(900, 1100));
    overrun = 1'($urandom_range(0, 1));
    write_cap(24'h000000);
    write_cap(24'hFFFFFF);
    write_cap(24'($urandom));
    write_cap($urandom_range(0, 1) ? size : size + 24'($urandom_range(1, 5000)));
    cfg_we <= 1'b0;

    add_row(1'b1, 8'h00, 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_TURN));
    add_row(1'b0, 8'h11, 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, size[7:0], 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, size[15:8], 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, size[23:16], 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, 8'b0011_0101, 1'b1, mk(1'b0, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, 8'h00, 1'b1, mk(1'b1, 8'h00, lz11d_pkg::ST_RUN));
    add_row(1'b0, 8'hFF, 1'b1, mk(1'b1, 8'hFF, lz11d_pkg::ST_RUN));
    add_row(1'b0, 8'h20, 1'b0, '0);
    add_row(1'b0, 8'h01, 1'b0, '0);
    add_row(1'b0, 8'hA5, 1'b0, '0);
    add_row(1'b1, 8'h00, 1'b0, '0);
    add_row(1'b1, 8'h00, 1'b0, '0);
    add_row(1'b1, 8'h00, 1'b0, '0);
    add_row(1'b1, 8'h00, 1'b0, '0);
    foreach (stim_rows[i])
      send_item(stim_rows[i].act, stim_rows[i].data, stim_rows[i].typed, stim_rows[i].res);

    items = 0;
    tail = 0;
    while (tail < 12) begin
      if (items % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (items == 500) drain();
      act = 1'b0;
      b = 8'($urandom);
      if (m_phase == lz11d_pkg::PH_DONE || m_phase == lz11d_pkg::PH_ERROR) begin
        act = 1'($urandom_range(0, 1));
        tail++;
      end else if ($urandom_range(0, 29) == 0) begin
        act = (m_phase != lz11d_pkg::PH_COPY);
      end else if (token_q.size() != 0) begin
        b = token_q.pop_front();
      end else if (m_phase == lz11d_pkg::PH_COPY) begin
        act = 1'b1;
      end else if (m_phase == lz11d_pkg::PH_FLAG) begin
        if (!overrun && int'(m_size) - int'(m_made) < 24) b = 8'h00;
      end else if (m_tidx == 0 && m_flags[7 - (m_fpos & 7)] == 1'b1) begin
        queue_token(overrun);
        b = token_q.pop_front();
      end
      send_item(act, b, 1'b0, '0);
      items++;
    end

    drain();
    write_cap(24'h000000);
    write_cap(24'hFFFFFF);
    cfg_we <= 1'b0;
    send_item(1'b0, 8'h3C, 1'b0, '0);
    send_item(1'b1, 8'hC3, 1'b0, '0);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
